/* design/brm_pkg.sv */
// Shared constants, types and state codes of the block RMS meter.
package brm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS    = SAMPLE_BITS + 1;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
   localparam int SUM_BITS    = 43;
   localparam int COUNT_BITS  = 13;
   localparam int LEVEL_BITS  = 16;
   localparam int MEAN_BITS   = 32;
   localparam int DIV_STEPS   = SUM_BITS;
   localparam int SQRT_STEPS  = MEAN_BITS / 2;
   localparam int STEP_BITS   = 6;

   localparam logic [COUNT_BITS-1:0] MAX_SAMPLES = COUNT_BITS'(4096);
   localparam logic [SUM_BITS-1:0]   SUM_MAX     = {SUM_BITS{1'b1}};
   localparam logic [LEVEL_BITS:0]   LEVEL_MAX   = (LEVEL_BITS + 1)'(32768);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_div;
      logic div_step;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

/* design/brm_ctrl.sv */
// Controller of the block RMS meter: sequences accumulate, divide, root and output.
module brm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_last,
   output logic                         req_ready,
   input  brm_pkg::status_type          status,
   output brm_pkg::cmd_type             cmd
);

   brm_pkg::state_type                state_ff, state_in;
   logic [brm_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                              step_last;

   assign step_last = (step_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brm_pkg::ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state. The block ends with the beat that carries the last flag.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brm_pkg::ST_ACCUM: begin
            if (cmd.accept && req_last) state_in = brm_pkg::ST_FLUSH;
         end
         brm_pkg::ST_FLUSH: state_in = brm_pkg::ST_DIV;
         brm_pkg::ST_DIV: begin
            if (step_last) state_in = brm_pkg::ST_SQRT;
         end
         brm_pkg::ST_SQRT: begin
            if (step_last) state_in = brm_pkg::ST_OUT;
         end
         brm_pkg::ST_OUT: begin
            if (status.out_free) state_in = brm_pkg::ST_ACCUM;
         end
         default: state_in = brm_pkg::ST_ACCUM;
      endcase
   end

   // Iteration counter for the divide and root passes.
   always_comb begin
      step_in = step_ff;
      unique case (state_ff)
         brm_pkg::ST_FLUSH: step_in = brm_pkg::STEP_BITS'(brm_pkg::DIV_STEPS - 1);
         brm_pkg::ST_DIV: begin
            if (step_last) step_in = brm_pkg::STEP_BITS'(brm_pkg::SQRT_STEPS - 1);
            else           step_in = step_ff - 1'b1;
         end
         brm_pkg::ST_SQRT: begin
            if (!step_last) step_in = step_ff - 1'b1;
         end
         default: step_in = step_ff;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = (state_ff == brm_pkg::ST_ACCUM);
      cmd.accept    = req_ready && req_valid;
      cmd.load_div  = (state_ff == brm_pkg::ST_FLUSH);
      cmd.div_step  = (state_ff == brm_pkg::ST_DIV);
      cmd.sqrt_step = (state_ff == brm_pkg::ST_SQRT);
      cmd.out_load  = (state_ff == brm_pkg::ST_OUT) && status.out_free;
   end

endmodule

/* design/brm_dp.sv */
// Datapath of the block RMS meter: square accumulator, divider, root unit, output register.
module brm_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  brm_pkg::cmd_type                       cmd,
   output brm_pkg::status_type                    status,
   input  logic signed [brm_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [brm_pkg::LEVEL_BITS-1:0]         rsp_rms_level,
   output logic [brm_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   output logic                                   rsp_overflow
);

   // Accumulation.
   logic [brm_pkg::MAG_BITS-1:0]      sample_ext, mag;
   logic [2*brm_pkg::MAG_BITS-1:0]    prod;
   logic [brm_pkg::SQ_BITS-1:0]       sq_ff, sq_in;
   logic [brm_pkg::SUM_BITS:0]        sum_wide;
   logic [brm_pkg::SUM_BITS-1:0]      sum_sat;
   logic [brm_pkg::SUM_BITS-1:0]      sum_ff, sum_in;
   logic [brm_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                              ovf_ff, ovf_in;
   logic                              room;

   // Division and root.
   logic [brm_pkg::SUM_BITS-1:0]      quot_ff, quot_in;
   logic [brm_pkg::COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic                              ovf_hold_ff, ovf_hold_in;
   logic [brm_pkg::COUNT_BITS-1:0]    drem_ff, drem_in;
   logic [brm_pkg::COUNT_BITS:0]      drem_sh;
   logic                              div_fits;
   logic [brm_pkg::LEVEL_BITS-1:0]    root_ff, root_in;
   logic [brm_pkg::LEVEL_BITS:0]      srem_ff, srem_in;
   logic [brm_pkg::LEVEL_BITS+2:0]    srem_sh, trial;
   logic                              sqrt_fits;

   // Output register.
   logic                              out_vld_ff, out_vld_in;
   logic [brm_pkg::LEVEL_BITS-1:0]    out_level_ff, out_level_in;
   logic [brm_pkg::COUNT_BITS-1:0]    out_count_ff, out_count_in;
   logic                              out_ovf_ff, out_ovf_in;

   assign sample_ext = {req_sample[brm_pkg::SAMPLE_BITS-1], req_sample};
   assign mag  = req_sample[brm_pkg::SAMPLE_BITS-1] ? (brm_pkg::MAG_BITS'(0) - sample_ext)
                                                     : sample_ext;
   assign prod = (2*brm_pkg::MAG_BITS)'(mag) * (2*brm_pkg::MAG_BITS)'(mag);
   assign room = (count_ff < brm_pkg::MAX_SAMPLES);

   assign sum_wide = {1'b0, sum_ff} + (brm_pkg::SUM_BITS + 1)'(sq_ff);
   assign sum_sat  = sum_wide[brm_pkg::SUM_BITS] ? brm_pkg::SUM_MAX
                                                 : sum_wide[brm_pkg::SUM_BITS-1:0];

   always_comb begin
      sq_in    = '0;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sum_in   = sum_sat;
      if (cmd.accept) begin
         if (room) begin
            sq_in    = prod[brm_pkg::SQ_BITS-1:0];
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load_div) begin
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Restoring divide, one quotient bit a cycle; the quotient shifts in
   // where the dividend shifts out.
   assign drem_sh  = {drem_ff, quot_ff[brm_pkg::SUM_BITS-1]};
   assign div_fits = (drem_sh >= {1'b0, divisor_ff});

   // Digit-by-digit square root over the low word of the quotient.
   assign srem_sh   = {srem_ff, quot_ff[brm_pkg::MEAN_BITS-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign sqrt_fits = (srem_sh >= trial);

   always_comb begin
      quot_in     = quot_ff;
      divisor_in  = divisor_ff;
      ovf_hold_in = ovf_hold_ff;
      drem_in     = drem_ff;
      root_in     = root_ff;
      srem_in     = srem_ff;
      if (cmd.load_div) begin
         quot_in     = sum_sat;
         divisor_in  = count_ff;
         ovf_hold_in = ovf_ff;
         drem_in     = '0;
         root_in     = '0;
         srem_in     = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[brm_pkg::SUM_BITS-2:0], div_fits};
         drem_in = div_fits ? brm_pkg::COUNT_BITS'(drem_sh - {1'b0, divisor_ff})
                            : drem_sh[brm_pkg::COUNT_BITS-1:0];
      end else if (cmd.sqrt_step) begin
         quot_in = {quot_ff[brm_pkg::SUM_BITS-3:0], 2'b00};
         root_in = {root_ff[brm_pkg::LEVEL_BITS-2:0], sqrt_fits};
         srem_in = sqrt_fits ? (brm_pkg::LEVEL_BITS + 1)'(srem_sh - trial)
                             : srem_sh[brm_pkg::LEVEL_BITS:0];
      end
   end

   assign status.out_free = !out_vld_ff || rsp_ready;

   always_comb begin
      out_vld_in   = out_vld_ff && !rsp_ready;
      out_level_in = out_level_ff;
      out_count_in = out_count_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.out_load) begin
         out_vld_in   = 1'b1;
         out_level_in = root_ff;
         out_count_in = divisor_ff;
         out_ovf_in   = ovf_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff      <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         sq_ff      <= sq_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      divisor_ff   <= divisor_in;
      ovf_hold_ff  <= ovf_hold_in;
      drem_ff      <= drem_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      out_level_ff <= out_level_in;
      out_count_ff <= out_count_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_rms_level    = out_level_ff;
   assign rsp_sample_count = out_count_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

/* design/block_rms_meter.sv */
// Top level of the block RMS meter: controller, datapath and checks.
// Samples of a block are taken one beat per cycle; each square is registered, then summed.
// After the beat marked last, the meter flushes, runs the divide pass (one quotient bit per
// step) and the root pass (one result bit per step); rsp_valid rises when the output is free.
// The next block's beats wait for that load, longer while the previous report waits unread.
// Synchronous active-high reset empties the sum, the count, the overflow mark and the output.
module block_rms_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [brm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [brm_pkg::LEVEL_BITS-1:0]         rsp_rms_level,
   output logic [brm_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   output logic                                   rsp_overflow
);

   brm_pkg::cmd_type    cmd;
   brm_pkg::status_type status;

   // The controller decides when beats are taken and steps the divider
   // and the root unit; the datapath holds all arithmetic and the result.
   brm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last_sample),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

   // Once the last beat of a block is taken, no further beat is taken until
   // the result has been worked out.
   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_sample) |=> !req_ready)
      else $error("beat taken straight after the last beat of a block");

   // Every result counts at least one sample and no more than the limit.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0 && rsp_sample_count <= brm_pkg::MAX_SAMPLES))
      else $error("result sample count out of range");

   // A block that ran over the limit reports exactly the limit as its count.
   a_overflow_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> rsp_sample_count == brm_pkg::MAX_SAMPLES)
      else $error("overflowed block without a saturated count");

   // The level never exceeds full scale.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_rms_level} <= brm_pkg::LEVEL_MAX))
      else $error("RMS level beyond full scale");

endmodule

/* sim/brm_checker.sv */
// Checker for the block RMS meter: predicts each block's level report and compares it.
`timescale 1ns / 100ps

module brm_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [brm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_last_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [brm_pkg::LEVEL_BITS-1:0]         rsp_rms_level,
   input  logic [brm_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   input  logic                                   rsp_overflow,
   output int                                     mismatches,
   output int                                     outstanding
);

   typedef struct packed {
      logic [brm_pkg::LEVEL_BITS-1:0] level;
      logic [brm_pkg::COUNT_BITS-1:0] count;
      logic                           clipped;
   } level_report_type;

   level_report_type               due_reports[$];
   logic [brm_pkg::SUM_BITS-1:0]   energy;
   logic [brm_pkg::COUNT_BITS-1:0] taken;
   logic                           clipped;

   // Largest r with r * r <= x, built one bit at a time from the top.
   function automatic logic [brm_pkg::LEVEL_BITS-1:0] floor_root(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      int          b;
      root = '0;
      for (b = brm_pkg::LEVEL_BITS; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) begin
            root = trial;
         end
      end
      return root[brm_pkg::LEVEL_BITS-1:0];
   endfunction

   always @(posedge clock) begin : watch
      level_report_type want;
      logic [63:0]      magnitude;
      logic [63:0]      total;
      if (reset) begin
         due_reports.delete();
         energy      = '0;
         taken       = '0;
         clipped     = 1'b0;
         mismatches  = 0;
      end else begin
         // A report leaving now belongs to an earlier block, so check before predicting.
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               $display("%0t: report with none expected: level %0d count %0d overflow %0b",
                        $time, rsp_rms_level, rsp_sample_count, rsp_overflow);
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_rms_level !== want.level) begin
                  $display("%0t: rms_level expected %0d, got %0d",
                           $time, want.level, rsp_rms_level);
                  mismatches++;
               end
               if (rsp_sample_count !== want.count) begin
                  $display("%0t: sample_count expected %0d, got %0d",
                           $time, want.count, rsp_sample_count);
                  mismatches++;
               end
               if (rsp_overflow !== want.clipped) begin
                  $display("%0t: overflow expected %0b, got %0b",
                           $time, want.clipped, rsp_overflow);
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            if (taken >= brm_pkg::MAX_SAMPLES) begin
               clipped = 1'b1;
            end else begin
               magnitude = 64'(req_sample < 0 ? -int'(req_sample) : int'(req_sample));
               total     = 64'(energy) + magnitude * magnitude;
               energy    = (total > 64'(brm_pkg::SUM_MAX)) ? brm_pkg::SUM_MAX
                                                          : total[brm_pkg::SUM_BITS-1:0];
               taken++;
            end
            if (req_last_sample) begin
               want.level   = floor_root(64'(energy) / 64'(taken));
               want.count   = taken;
               want.clipped = clipped;
               due_reports.push_back(want);
               energy  = '0;
               taken   = '0;
               clipped = 1'b0;
            end
         end
      end
      outstanding = due_reports.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for the block RMS meter: clock, reset, sample stimulus and verdict.
`timescale 1ns / 100ps

module tb;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic signed [brm_pkg::SAMPLE_BITS-1:0] req_sample;
   logic                                   req_last_sample;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [brm_pkg::LEVEL_BITS-1:0]         rsp_rms_level;
   logic [brm_pkg::COUNT_BITS-1:0]         rsp_sample_count;
   logic                                   rsp_overflow;

   int mismatches;
   int outstanding;

   // Stimulus shaping shared by the sender and the receiver.
   bit calm;        // set for the closing stretch: no idling on either side
   bit hold_req;    // asks the receiver for its one long hold-off
   bit hold_done;
   int gap_odds;    // one beat in gap_odds is preceded by a gap; zero means none

   block_rms_meter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

   brm_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop, well beyond the slowest correct run. Even if every one of the
   // fewer than 2000 beats closed a block of its own and waited out the longest gap,
   // the divide and root passes and the longest stall, the run would still end
   // well before this time.
   initial begin
      #(5_000_000);
      $display("tb: errors");
      $finish;
   end

   // Offers one sample beat and returns at the falling edge after it is taken.
   // Valid is left high, so back-to-back beats keep it high without a dip; it is
   // only lowered for a gap or at the very end.
   task automatic send_beat(input logic signed [brm_pkg::SAMPLE_BITS-1:0] value,
                            input logic is_last);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_sample      = value;
      req_last_sample = is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sample values lean on the extremes and on small magnitudes; the rest are
   // uniform, so that every bit of the sample is exercised both ways.
   function automatic logic signed [brm_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'($urandom_range(0, 15)) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // A whole block: random content, or nothing but full-scale negative samples.
   task automatic send_block(input int length, input bit full_scale);
      int i;
      for (i = 0; i < length; i++) begin
         send_beat(full_scale ? 16'sh8000 : pick_sample(), i == length - 1);
      end
   endtask

   // Receiver: short random stalls, one long hold-off on request, none at the end.
   // The long hold-off lets the meter finish a block with its report still unread,
   // so the next block's end finds the output occupied and req_ready must stay low.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      int beats;
      int blocks;
      int pick;
      int length;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_last_sample = 1'b0;
      calm            = 1'b0;
      hold_req        = 1'b0;
      hold_done       = 1'b0;
      gap_odds        = 4;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single-sample blocks at the corners of the range. Full-scale negative
      // squares to exactly one, which must give a level of 32768.
      send_beat(16'sh0000, 1'b1);
      send_beat(16'sh8000, 1'b1);
      send_beat(16'sh7FFF, 1'b1);
      send_beat(-16'sd1, 1'b1);
      send_beat(16'sd1, 1'b1);
      // Mixed signs and extremes in one block.
      send_beat(16'sd1, 1'b0);
      send_beat(-16'sd1, 1'b0);
      send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sh8000, 1'b1);
      // Alternating bit patterns.
      send_beat(16'sh5555, 1'b0);
      send_beat(16'shAAAA, 1'b0);
      send_beat(16'sd100, 1'b1);
      // Silence over two samples, then a mean that must be floored twice.
      send_beat(16'sh0000, 1'b0);
      send_beat(16'sh0000, 1'b1);
      send_beat(16'sd3, 1'b0);
      send_beat(-16'sd4, 1'b1);

      // Random blocks, mostly short, with one longer block made only of
      // full-scale negative samples, whose level must again be 32768.
      hold_req = 1'b1;
      beats    = 0;
      blocks   = 0;
      while (beats < 1600) begin
         if (beats > 1350) begin
            calm = 1'b1;
         end
         gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
         pick     = $urandom_range(0, 19);
         if (pick < 14) begin
            length = $urandom_range(1, 8);
         end else if (pick < 19) begin
            length = $urandom_range(9, 40);
         end else begin
            length = $urandom_range(41, 300);
         end
         send_block(length, 1'b0);
         beats += length;
         blocks++;
         if (blocks == 20) begin
            send_block(64, 1'b1);
            beats += 64;
         end
      end
      req_valid       = 1'b0;
      req_last_sample = 1'b0;

      // Drain, then allow a full divide-and-root time for any stray report.
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);

      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/brm_pkg.sv
design/brm_ctrl.sv
design/brm_dp.sv
design/block_rms_meter.sv
sim/brm_checker.sv
sim/tb.sv
